[design/rfrd_pkg.sv]
// ----------------------------------------------------------------------------
// rfrd_pkg
// Shared types and constants for the run-length frame decoder.
// ----------------------------------------------------------------------------
package rfrd_pkg;

    // Pixel count of one frame, used for the past-end flag
    localparam int FRAME_PIXELS = 64000;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 17;
    localparam int LENGTH_W = 16;
    localparam int COLOR_W  = 8;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

    // Opcodes of the compressed stream
    localparam logic [BYTE_W-1:0] OP_END    = 8'd0;
    localparam logic [BYTE_W-1:0] OP_SINGLE = 8'd1;
    localparam logic [BYTE_W-1:0] OP_DOUBLE = 8'd2;
    localparam logic [BYTE_W-1:0] OP_FILL8  = 8'd3;
    // Lowest opcode of the 16-bit count fill; every higher value means the same
    localparam logic [BYTE_W-1:0] OP_FILL16 = 8'd4;

    // Widths of the stream words
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_OPCODE = 6'b000001,
        PH_COLOR  = 6'b000010,
        PH_CNT8   = 6'b000100,
        PH_CNT_LO = 6'b001000,
        PH_CNT_HI = 6'b010000,
        PH_IDLE   = 6'b100000
    } phase_t;

    // One input word
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_start;
    } in_item_t;

    // One run command
    typedef struct packed {
        logic [OFFSET_W-1:0] run_start;
        logic [LENGTH_W-1:0] run_length;
        logic [COLOR_W-1:0]  run_color;
        logic                is_skip;
        logic                frame_end;
        logic                past_end;
    } run_t;

    // Result of parsing one byte
    typedef struct packed {
        logic valid;
        run_t run;
    } parse_result_t;

endpackage

[design/rfrd_in_stage.sv]
// ----------------------------------------------------------------------------
// rfrd_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module rfrd_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  rfrd_pkg::in_item_t            s_item,
    input  logic                          consume,
    output logic                          item_valid,
    output rfrd_pkg::in_item_t            item
);
    import rfrd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // Take a new word when empty or when the held one leaves this cycle
    assign s_tready = !valid_reg || consume;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[design/rfrd_parser.sv]
// ----------------------------------------------------------------------------
// rfrd_parser
// Opcode/operand parser: tracks phase, offset and count, builds run commands.
// ----------------------------------------------------------------------------
module rfrd_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  rfrd_pkg::in_item_t            item,
    output rfrd_pkg::parse_result_t       result
);
    import rfrd_pkg::*;

    localparam logic [OFFSET_W:0] FRAME_LIMIT = (OFFSET_W+1)'(FRAME_PIXELS);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic [LENGTH_W-1:0] count_reg;
    logic [LENGTH_W-1:0] count_next;

    phase_t              phase_cur;
    logic [OFFSET_W-1:0] offset_cur;
    logic [LENGTH_W-1:0] count_cur;
    logic [OFFSET_W:0]   run_end;
    logic [BYTE_W-1:0]   b;

    assign b = item.data_byte;

    // Frame start restarts the parser before this byte is looked at
    always_comb begin
        if (item.frame_start) begin
            phase_cur  = PH_OPCODE;
            offset_cur = '0;
            count_cur  = '0;
        end else begin
            phase_cur  = phase_reg;
            offset_cur = offset_reg;
            count_cur  = count_reg;
        end
    end

    assign run_end = {1'b0, offset_cur} + {{(OFFSET_W+1-LENGTH_W){1'b0}}, count_cur};

    // Decode one byte
    always_comb begin
        phase_next  = phase_cur;
        offset_next = offset_cur;
        count_next  = count_cur;
        result      = '0;
        case (phase_cur)
            PH_OPCODE: begin
                if (b == OP_END) begin
                    result.valid         = 1'b1;
                    result.run.run_start = offset_cur;
                    result.run.frame_end = 1'b1;
                    phase_next           = PH_IDLE;
                    count_next           = '0;
                end else if (b == OP_SINGLE) begin
                    count_next = LENGTH_W'(1);
                    phase_next = PH_COLOR;
                end else if (b == OP_DOUBLE) begin
                    count_next = LENGTH_W'(2);
                    phase_next = PH_COLOR;
                end else if (b == OP_FILL8) begin
                    count_next = '0;
                    phase_next = PH_CNT8;
                end else begin
                    count_next = '0;
                    phase_next = PH_CNT_LO;
                end
            end
            PH_CNT8: begin
                count_next = {{(LENGTH_W-BYTE_W){1'b0}}, b};
                phase_next = PH_COLOR;
            end
            PH_CNT_LO: begin
                count_next = {{(LENGTH_W-BYTE_W){1'b0}}, b};
                phase_next = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                count_next = {b, count_cur[BYTE_W-1:0]};
                phase_next = PH_COLOR;
            end
            PH_COLOR: begin
                result.valid          = 1'b1;
                result.run.run_start  = offset_cur;
                result.run.run_length = count_cur;
                result.run.run_color  = b;
                result.run.is_skip    = (b == '0);
                result.run.past_end   = (run_end > FRAME_LIMIT);
                // Saturate the offset at its top value
                offset_next = run_end[OFFSET_W] ? OFFSET_MAX : run_end[OFFSET_W-1:0];
                count_next  = '0;
                phase_next  = PH_OPCODE;
            end
            default: begin
                // Idle after frame end: drop bytes until a frame start
                phase_next = phase_cur;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_OPCODE;
            offset_reg <= '0;
            count_reg  <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/rfrd_out_stage.sv]
// ----------------------------------------------------------------------------
// rfrd_out_stage
// Result register: holds one run command until the sink takes it.
// ----------------------------------------------------------------------------
module rfrd_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  rfrd_pkg::run_t                run_in,
    output logic                          out_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output rfrd_pkg::run_t                run_out
);
    import rfrd_pkg::*;

    logic valid_reg;
    logic valid_next;
    run_t run_reg;

    // Slot is free when empty or when the held word leaves this cycle
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            run_reg <= run_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign run_out  = run_reg;

endmodule

[design/rle_frame_run_decoder_unit.sv]
// ----------------------------------------------------------------------------
// rle_frame_run_decoder_unit
// Path: a run command shows on m_tvalid after its color byte is accepted and
// has passed the input register, then the result register.
// Throughput: one byte per cycle unless a run command waits for room in the result register.
// Reset: synchronous active-low aresetn empties both registers and puts the
// parser in the opcode phase with offset and count at zero.
// ----------------------------------------------------------------------------
module rle_frame_run_decoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rfrd_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic [rfrd_pkg::S_TUSER_W-1:0]    s_tuser,   // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [16:0] run_start, [32:17] run_length, [40:33] run_color, [47:41] zero
    output logic [rfrd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [rfrd_pkg::M_TUSER_W-1:0]    m_tuser,   // [0] is_skip, [1] past_end
    output logic                              m_tlast    // frame_end
);
    import rfrd_pkg::*;

    in_item_t      s_item;
    in_item_t      item;
    logic          item_valid;
    logic          consume;
    logic          out_free;
    logic          load;
    parse_result_t result;
    run_t          run_out;

    assign s_item.data_byte   = s_tdata[BYTE_W-1:0];
    assign s_item.frame_start = s_tuser[0];

    rfrd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    // Advance a byte unless its result has no room
    assign consume = item_valid && (!result.valid || out_free);
    assign load    = consume && result.valid;

    rfrd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (consume),
        .item    (item),
        .result  (result)
    );

    rfrd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .run_in   (result.run),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .run_out  (run_out)
    );

    // Pack the result word
    assign m_tdata = {{(M_TDATA_W-OFFSET_W-LENGTH_W-COLOR_W){1'b0}},
                      run_out.run_color, run_out.run_length, run_out.run_start};
    assign m_tuser = {run_out.past_end, run_out.is_skip};
    assign m_tlast = run_out.frame_end;

endmodule

[sim/rle_frame_run_decoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// rle_frame_run_decoder_unit_tb
// Self-checking bench for the run-length frame decoder. Byte words are fed as
// directed corner cases, a back-pressure burst and random well-formed frames
// mixed with noise and broken commands. A local decoder predicts every run
// command, and each accepted result word is compared field by field.
// ----------------------------------------------------------------------------
module rle_frame_run_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfrd_pkg::*;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    rle_frame_run_decoder_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Decoder state as predicted from the accepted byte words
    phase_t              pred_phase  = PH_OPCODE;
    logic [OFFSET_W-1:0] pred_offset = '0;
    logic [LENGTH_W-1:0] pred_count  = '0;

    run_t expected_runs[$];
    int   fail_count  = 0;
    int   words_sent  = 0;
    int   cycle_no    = 0;
    int   hold_until  = 0;
    int   burst_left  = 0;
    bit   tx_steady   = 1'b0;
    bit   rx_steady   = 1'b0;
    logic [15:0] rx_pattern = 16'hB5A3;

    // Predict the run command, if any, that one byte word causes
    function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                       output run_t run);
        logic [OFFSET_W:0] run_end;
        run = '0;
        decode_byte = 1'b0;
        if (fs) begin
            pred_offset = '0;
            pred_phase  = PH_OPCODE;
            pred_count  = '0;
        end
        case (pred_phase)
            PH_OPCODE: begin
                if (b == OP_END) begin
                    run.run_start = pred_offset;
                    run.frame_end = 1'b1;
                    pred_phase    = PH_IDLE;
                    pred_count    = '0;
                    decode_byte   = 1'b1;
                end else if (b == OP_SINGLE) begin
                    pred_count = 16'd1;
                    pred_phase = PH_COLOR;
                end else if (b == OP_DOUBLE) begin
                    pred_count = 16'd2;
                    pred_phase = PH_COLOR;
                end else if (b == OP_FILL8) begin
                    pred_count = '0;
                    pred_phase = PH_CNT8;
                end else begin
                    pred_count = '0;
                    pred_phase = PH_CNT_LO;
                end
            end
            PH_CNT8: begin
                pred_count = {8'd0, b};
                pred_phase = PH_COLOR;
            end
            PH_CNT_LO: begin
                pred_count = {8'd0, b};
                pred_phase = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                pred_count = {b, pred_count[7:0]};
                pred_phase = PH_COLOR;
            end
            PH_COLOR: begin
                run_end        = {1'b0, pred_offset} + {2'b00, pred_count};
                run.run_start  = pred_offset;
                run.run_length = pred_count;
                run.run_color  = b;
                run.is_skip    = (b == 8'd0);
                run.past_end   = (run_end > FRAME_PIXELS);
                pred_offset    = (run_end > OFFSET_MAX) ? OFFSET_MAX
                                                        : run_end[OFFSET_W-1:0];
                pred_phase     = PH_OPCODE;
                pred_count     = '0;
                decode_byte    = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Count cycles for the receiver hold-off
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    // Drive the receiver: long hold-off, steady, or a rotating stall pattern
    always @(negedge aclk) begin
        if (cycle_no < hold_until) begin
            m_tready = 1'b0;
        end else if (rx_steady) begin
            m_tready = 1'b1;
        end else begin
            rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
            if ($urandom_range(0, 47) == 0)
                rx_pattern = 16'($urandom);
            m_tready = rx_pattern[0];
        end
    end

    // Check each accepted result word against the oldest expected run
    run_t exp_run;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_runs.size() == 0) begin
                note_failure($sformatf("unexpected run tdata=%h tuser=%b tlast=%b",
                                       m_tdata, m_tuser, m_tlast));
            end else begin
                exp_run = expected_runs.pop_front();
                if (m_tdata[16:0]  !== exp_run.run_start  ||
                    m_tdata[32:17] !== exp_run.run_length ||
                    m_tdata[40:33] !== exp_run.run_color  ||
                    m_tuser[0]     !== exp_run.is_skip    ||
                    m_tuser[1]     !== exp_run.past_end   ||
                    m_tlast        !== exp_run.frame_end)
                    note_failure($sformatf(
                        {"exp start=%0d len=%0d color=%0d skip=%b past=%b end=%b",
                         " got start=%0d len=%0d color=%0d skip=%b past=%b end=%b"},
                        exp_run.run_start, exp_run.run_length, exp_run.run_color,
                        exp_run.is_skip, exp_run.past_end, exp_run.frame_end,
                        m_tdata[16:0], m_tdata[32:17], m_tdata[40:33],
                        m_tuser[0], m_tuser[1], m_tlast));
            end
        end
    end

    // Offer one byte word, in bursts with random gaps, and predict on accept
    task automatic send_word(input logic [7:0] b, input logic fs);
        run_t run;
        if (!tx_steady && burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = fs;
        do @(posedge aclk); while (!s_tready);
        if (decode_byte(b, fs, run))
            expected_runs.push_back(run);
        words_sent++;
        @(negedge aclk);
    endtask

    // Pause the sender until every expected run has come out
    task automatic wait_for_drain();
        s_tvalid = 1'b0;
        while (expected_runs.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    // Corner cases: every opcode, skip color, zero and maximum counts,
    // offset saturation, frame end, ignored bytes and a restart mid-command
    task automatic test_directed_runs();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        send_word(OP_SINGLE, 1'b1);  send_word(8'h55, 1'b0);
        send_word(OP_DOUBLE, 1'b0);  send_word(8'h00, 1'b0);
        send_word(OP_FILL8, 1'b0);   send_word(8'h00, 1'b0);  send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);      send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);      send_word(8'h80, 1'b0);
        // this run pushes the offset past its maximum
        send_word(OP_FILL16, 1'b0);  send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);      send_word(8'h01, 1'b0);
        send_word(OP_FILL8, 1'b0);   send_word(8'hFF, 1'b0);  send_word(8'hAA, 1'b0);
        send_word(OP_END, 1'b0);
        // bytes after the terminator are dropped
        send_word(OP_SINGLE, 1'b0);  send_word(OP_END, 1'b0);
        // restart on what would have been a count byte
        send_word(OP_FILL8, 1'b1);   send_word(OP_DOUBLE, 1'b1); send_word(8'h07, 1'b0);
    endtask

    // Hold the receiver off while the sender keeps offering words
    task automatic test_output_backpressure();
        tx_steady  = 1'b1;
        hold_until = cycle_no + 300;
        for (int i = 0; i < 30; i++) begin
            send_word(OP_DOUBLE, i == 0);
            send_word(8'(i * 9), 1'b0);
        end
        wait_for_drain();
        tx_steady = 1'b0;
    endtask

    function automatic logic random_restart();
        return $urandom_range(0, 39) == 0;
    endfunction

    function automatic logic [7:0] random_color();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    // Random frames of well-formed commands, with noise and broken commands
    task automatic test_random_frames(input int n_words);
        int  stop_at;
        int  frame_left;
        int  pick;
        int  next_mode;
        logic fs;
        stop_at    = words_sent + n_words;
        frame_left = 0;
        next_mode  = words_sent;
        while (words_sent < stop_at) begin
            // change the idling mix now and then
            if (words_sent >= next_mode) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
                next_mode = words_sent + $urandom_range(50, 150);
            end
            fs = 1'b0;
            if (frame_left == 0) begin
                frame_left = $urandom_range(3, 40);
                fs = 1'b1;
            end
            fs = fs | random_restart();
            frame_left--;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_word(OP_SINGLE, fs);
                send_word(random_color(), random_restart());
            end else if (pick < 50) begin
                send_word(OP_DOUBLE, fs);
                send_word(random_color(), random_restart());
            end else if (pick < 68) begin
                send_word(OP_FILL8, fs);
                send_word(8'($urandom), random_restart());
                send_word(random_color(), random_restart());
            end else if (pick < 85) begin
                send_word(8'($urandom_range(OP_FILL16, 255)), fs);
                send_word(8'($urandom), random_restart());
                send_word(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 3)),
                          random_restart());
                send_word(random_color(), random_restart());
            end else if (pick < 92) begin
                send_word(OP_END, fs);
                // trailing bytes that the idle parser drops
                repeat ($urandom_range(0, 2)) send_word(8'($urandom), 1'b0);
                frame_left = 0;
            end else begin
                send_word(8'($urandom), 1'($urandom_range(0, 1)));
            end
        end
        s_tvalid = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed_runs();
        wait_for_drain();
        test_output_backpressure();
        test_random_frames(1480);
        wait_for_drain();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && expected_runs.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
design/rfrd_pkg.sv
design/rfrd_in_stage.sv
design/rfrd_parser.sv
design/rfrd_out_stage.sv
design/rle_frame_run_decoder_unit.sv
sim/rle_frame_run_decoder_unit_tb.sv
